// ===== sv/tmpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tmpq_pkg
// Shared types, codes and defaults of the two-mode priority job queue.
// ----------------------------------------------------------------------------
package tmpq_pkg;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_TAG_BITS    = 16;

   // Fixed field widths.
   localparam int SEQ_BITS       = 32;
   localparam int OUT_TAG_BITS   = 16;
   localparam int KIND_BITS      = 2;
   localparam int CLASS_BITS     = 3;
   localparam int OCC_BITS       = 5;
   localparam int STATUS_BITS    = 2;
   localparam int FLAG_BITS      = 7;
   localparam int REQ_TDATA_BITS = 32;
   localparam int RSP_TDATA_BITS = 64;

   // Request opcodes.
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Job kinds.
   localparam logic [KIND_BITS-1:0] KIND_QUERY   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FORWARD = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_INSERT  = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_DELETE  = 2'd3;

   // Priority classes, most urgent first.
   localparam logic [CLASS_BITS-1:0] CLASS_UPDATE = 3'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_ZIP    = 3'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_BOUND  = 3'd2;
   localparam logic [CLASS_BITS-1:0] CLASS_AREA   = 3'd3;
   localparam logic [CLASS_BITS-1:0] CLASS_PLAIN  = 3'd4;

   // Response status codes.
   localparam logic [STATUS_BITS-1:0] ST_ENQUEUED = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_RETURNED = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd3;

   // Bit positions of the presence flags inside the flag vector.
   localparam int FLAG_ZIP     = 0;
   localparam int FLAG_LAT_MIN = 1;
   localparam int FLAG_LAT_MAX = 2;
   localparam int FLAG_LON_MIN = 3;
   localparam int FLAG_LON_MAX = 4;
   localparam int FLAG_BOROUGH = 5;
   localparam int FLAG_AGENCY  = 6;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ENQ,
      S_SCAN,
      S_DEQ
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic enq_commit;
      logic scan_start;
      logic scan_step;
      logic deq_commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_free;
      logic scan_done;
   } dp_sts_type;

endpackage

// ===== sv/tmpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmpq_ctrl
// Sequencer of the job queue: takes one request, runs an enqueue or a
// dequeue scan, and commits the result once the response register is free.
// ----------------------------------------------------------------------------
module tmpq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_opcode,
   output logic                   req_tready,
   output tmpq_pkg::dp_cmd_type   cmd,
   input  tmpq_pkg::dp_sts_type   sts
);
   import tmpq_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               if (req_opcode == OP_DEQUEUE) begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end else begin
                  state_in = S_ENQ;
               end
            end
         end
         S_ENQ: begin
            if (sts.rsp_free) begin
               cmd.enq_commit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_DEQ;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_DEQ: begin
            if (sts.rsp_free) begin
               cmd.deq_commit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/tmpq_dp.sv =====
// ----------------------------------------------------------------------------
// tmpq_dp
// Datapath of the job queue: request register, entry memory with valid bits,
// sequence counter, minimum search over the entries and response register.
// ----------------------------------------------------------------------------
module tmpq_dp #(
   parameter int QUEUE_DEPTH = tmpq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int TAG_BITS    = tmpq_pkg::DEFAULT_TAG_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tmpq_pkg::dp_cmd_type                   cmd,
   output tmpq_pkg::dp_sts_type                   sts,
   input  logic                                   csr_wen,
   input  logic                                   csr_wdata,
   input  logic [tmpq_pkg::KIND_BITS-1:0]         req_job_kind,
   input  logic [tmpq_pkg::OUT_TAG_BITS-1:0]      req_job_tag,
   input  logic [tmpq_pkg::FLAG_BITS-1:0]         req_flags,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [tmpq_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [tmpq_pkg::OUT_TAG_BITS-1:0]      rsp_tag,
   output logic [tmpq_pkg::KIND_BITS-1:0]         rsp_kind,
   output logic [tmpq_pkg::CLASS_BITS-1:0]        rsp_class,
   output logic [tmpq_pkg::SEQ_BITS-1:0]          rsp_sequence,
   output logic [tmpq_pkg::OCC_BITS-1:0]          rsp_occupancy
);
   import tmpq_pkg::*;

   // Only the tag bits that fit both the input field and TAG_BITS are kept.
   localparam int TW    = (TAG_BITS < OUT_TAG_BITS) ? TAG_BITS : OUT_TAG_BITS;
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   typedef struct packed {
      logic [CLASS_BITS-1:0] cls;
      logic [SEQ_BITS-1:0]   seq;
      logic [KIND_BITS-1:0]  kind;
      logic [TW-1:0]         tag;
   } entry_type;

   function automatic logic [CLASS_BITS-1:0] job_class(
      input logic [KIND_BITS-1:0] kind,
      input logic [FLAG_BITS-1:0] flags
   );
      logic [CLASS_BITS-1:0] cls;
      if (kind == KIND_INSERT || kind == KIND_DELETE) begin
         cls = CLASS_UPDATE;
      end else if (flags[FLAG_ZIP]) begin
         cls = CLASS_ZIP;
      end else if (flags[FLAG_LAT_MIN] || flags[FLAG_LAT_MAX] ||
                   flags[FLAG_LON_MIN] || flags[FLAG_LON_MAX]) begin
         cls = CLASS_BOUND;
      end else if (flags[FLAG_BOROUGH] || flags[FLAG_AGENCY]) begin
         cls = CLASS_AREA;
      end else begin
         cls = CLASS_PLAIN;
      end
      return cls;
   endfunction

   // Configuration.
   logic fifo_mode_ff;

   // Latched request.
   entry_type req_ff;

   // Queue state.
   entry_type              mem [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] valid_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [SEQ_BITS-1:0]    next_seq_ff;

   // Scan state.
   logic [CNT_W-1:0] scan_cnt_ff;
   logic             cmp_vld_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   entry_type        rd_data_ff;
   logic             best_found_ff;
   logic [IDX_W-1:0] best_idx_ff;
   entry_type        best_ff;

   // Response register.
   logic                   rsp_valid_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [OUT_TAG_BITS-1:0] rsp_tag_ff;
   logic [KIND_BITS-1:0]   rsp_kind_ff;
   logic [CLASS_BITS-1:0]  rsp_class_ff;
   logic [SEQ_BITS-1:0]    rsp_seq_ff;
   logic [OCC_BITS-1:0]    rsp_occ_ff;

   logic             full;
   logic [IDX_W-1:0] free_idx;
   logic             rsp_free;
   logic [SEQ_BITS-1:0] seq_diff;
   logic             cand_first;
   logic             take;
   logic [CNT_W-1:0] count_up;
   logic [CNT_W-1:0] count_down;

   assign full       = (count_ff == DEPTH_CNT);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign count_up   = count_ff + CNT_W'(1);
   assign count_down = count_ff - CNT_W'(1);

   // Lowest-numbered free entry.
   always_comb begin
      free_idx = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   // Ordering of the candidate against the best entry so far. Sequence
   // numbers compare with wraparound through the sign of their difference.
   assign seq_diff = rd_data_ff.seq - best_ff.seq;
   always_comb begin
      if (!fifo_mode_ff && (rd_data_ff.cls != best_ff.cls)) begin
         cand_first = (rd_data_ff.cls < best_ff.cls);
      end else begin
         cand_first = seq_diff[SEQ_BITS-1];
      end
   end
   assign take = cmp_vld_ff && valid_ff[cmp_idx_ff] && (!best_found_ff || cand_first);

   assign sts.rsp_free  = rsp_free;
   assign sts.scan_done = (scan_cnt_ff == DEPTH_CNT) && !cmp_vld_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_mode_ff  <= 1'b1;
         valid_ff      <= '0;
         count_ff      <= '0;
         next_seq_ff   <= '0;
         scan_cnt_ff   <= '0;
         cmp_vld_ff    <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wen) begin
            fifo_mode_ff <= csr_wdata;
         end

         if (cmd.scan_start) begin
            scan_cnt_ff   <= '0;
            cmp_vld_ff    <= 1'b0;
            best_found_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            if (scan_cnt_ff != DEPTH_CNT) begin
               scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
               cmp_vld_ff  <= 1'b1;
            end else begin
               cmp_vld_ff <= 1'b0;
            end
            if (take) begin
               best_found_ff <= 1'b1;
            end
         end

         if (cmd.enq_commit && !full) begin
            valid_ff[free_idx] <= 1'b1;
            count_ff           <= count_up;
            next_seq_ff        <= next_seq_ff + SEQ_BITS'(1);
         end
         if (cmd.deq_commit && best_found_ff) begin
            valid_ff[best_idx_ff] <= 1'b0;
            count_ff              <= count_down;
         end

         if (cmd.enq_commit || cmd.deq_commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers and the entry memory.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff.cls  <= job_class(req_job_kind, req_flags);
         req_ff.seq  <= '0;
         req_ff.kind <= req_job_kind;
         req_ff.tag  <= TW'(req_job_tag);
      end

      if (cmd.enq_commit && !full) begin
         mem[free_idx] <= '{cls: req_ff.cls, seq: next_seq_ff,
                            kind: req_ff.kind, tag: req_ff.tag};
      end

      if (cmd.scan_step && (scan_cnt_ff != DEPTH_CNT)) begin
         rd_data_ff <= mem[scan_cnt_ff[IDX_W-1:0]];
         cmp_idx_ff <= scan_cnt_ff[IDX_W-1:0];
      end

      if (cmd.scan_step && take) begin
         best_ff     <= rd_data_ff;
         best_idx_ff <= cmp_idx_ff;
      end

      if (cmd.enq_commit) begin
         rsp_tag_ff   <= OUT_TAG_BITS'(req_ff.tag);
         rsp_kind_ff  <= req_ff.kind;
         rsp_class_ff <= req_ff.cls;
         if (full) begin
            rsp_status_ff <= ST_FULL;
            rsp_seq_ff    <= '0;
            rsp_occ_ff    <= OCC_BITS'(count_ff);
         end else begin
            rsp_status_ff <= ST_ENQUEUED;
            rsp_seq_ff    <= next_seq_ff;
            rsp_occ_ff    <= OCC_BITS'(count_up);
         end
      end else if (cmd.deq_commit) begin
         if (best_found_ff) begin
            rsp_status_ff <= ST_RETURNED;
            rsp_tag_ff    <= OUT_TAG_BITS'(best_ff.tag);
            rsp_kind_ff   <= best_ff.kind;
            rsp_class_ff  <= best_ff.cls;
            rsp_seq_ff    <= best_ff.seq;
            rsp_occ_ff    <= OCC_BITS'(count_down);
         end else begin
            rsp_status_ff <= ST_EMPTY;
            rsp_tag_ff    <= '0;
            rsp_kind_ff   <= '0;
            rsp_class_ff  <= '0;
            rsp_seq_ff    <= '0;
            rsp_occ_ff    <= OCC_BITS'(count_ff);
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_tag       = rsp_tag_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_class     = rsp_class_ff;
   assign rsp_sequence  = rsp_seq_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

// ===== sv/two_mode_priority_job_queue.sv =====
// ----------------------------------------------------------------------------
// two_mode_priority_job_queue
// Bounded job queue that hands out jobs by class and age, or by age alone.
// ----------------------------------------------------------------------------
// Each request either enqueues a job or dequeues the next one, and each
// request produces exactly one response. An enqueued job is stored in the
// lowest free slot with a running 32-bit sequence number and a class derived
// from its kind and query flags (insert or delete 0, zip code 1, any lat or
// lon bound 2, borough or agency 3, otherwise 4). A dequeue returns the stored
// job with the smallest key: in FIFO mode (csr_wdata written as 1, the reset
// value) the key is the sequence number alone, otherwise the class with ties
// going to the older job; sequence numbers compare with wraparound, and a
// full tie goes to the lower slot. The mode applies at the time of the
// dequeue, so changing it reorders jobs already stored. The mode register is
// written with csr_wen and should be changed only while the block is idle.
// The block works on one request at a time. An enqueue's response is
// registered when S_ENQ commits it, and the next request is taken in S_IDLE
// after that, so the block takes no new request before the last is done. A
// dequeue first runs a search in S_SCAN, which reads the entry memory through
// its single read port, one slot per cycle, and compares each slot against
// the best candidate so far; S_DEQ then registers the response. The
// response sits in an output register; a new request is accepted while it
// waits, and the next result is committed once that register is free.
// ----------------------------------------------------------------------------
module two_mode_priority_job_queue #(
   parameter int QUEUE_DEPTH = tmpq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int TAG_BITS    = tmpq_pkg::DEFAULT_TAG_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata, from bit 0: job_kind[1:0], job_tag[17:2], has_zip[18],
   // lat_lo[19], lat_hi[20], lon_lo[21], lon_hi[22],
   // has_borough[23], has_agency[24], zero fill [31:25].
   input  logic [tmpq_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // tuser: opcode (0 enqueue, 1 dequeue).
   input  logic                                  req_tuser,
   // Response channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata, from bit 0: out_tag[15:0], out_kind[17:16], out_class[20:18],
   // out_sequence[52:21], occupancy[57:53], zero fill [63:58].
   output logic [tmpq_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   // tuser: status[1:0].
   output logic [tmpq_pkg::STATUS_BITS-1:0]      rsp_tuser,
   // Configuration: fifo_mode.
   input  logic                                  csr_wen,
   input  logic                                  csr_wdata
);
   import tmpq_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   logic [KIND_BITS-1:0]    req_job_kind;
   logic [OUT_TAG_BITS-1:0] req_job_tag;
   logic [FLAG_BITS-1:0]    req_flags;

   logic [STATUS_BITS-1:0]  rsp_status;
   logic [OUT_TAG_BITS-1:0] rsp_tag;
   logic [KIND_BITS-1:0]    rsp_kind;
   logic [CLASS_BITS-1:0]   rsp_class;
   logic [SEQ_BITS-1:0]     rsp_sequence;
   logic [OCC_BITS-1:0]     rsp_occupancy;

   // Unpack the request; the flag vector keeps the tdata order.
   assign req_job_kind = req_tdata[1:0];
   assign req_job_tag  = req_tdata[17:2];
   assign req_flags    = req_tdata[24:18];

   tmpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   tmpq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .req_job_kind  (req_job_kind),
      .req_job_tag   (req_job_tag),
      .req_flags     (req_flags),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_status    (rsp_status),
      .rsp_tag       (rsp_tag),
      .rsp_kind      (rsp_kind),
      .rsp_class     (rsp_class),
      .rsp_sequence  (rsp_sequence),
      .rsp_occupancy (rsp_occupancy)
   );

   // Pack the response.
   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {6'd0, rsp_occupancy, rsp_sequence, rsp_class, rsp_kind, rsp_tag};

   // Only one request is in flight: the cycle after an acceptance the block
   // is busy with it.
   a_one_in_flight: assert property (
      @(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready
   ) else $error("request accepted while another is in progress");

   // A refused enqueue only happens with every slot taken.
   a_full_occupancy: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_FULL) |-> (rsp_occupancy == OCC_BITS'(QUEUE_DEPTH))
   ) else $error("full status with queue not full");

   // An empty dequeue reports an empty queue and a blank job.
   a_empty_blank: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_EMPTY) |->
         (rsp_occupancy == '0 && rsp_sequence == '0 && rsp_tag == '0)
   ) else $error("empty status with nonzero fields");

   // Every reported class is a defined priority class.
   a_class_range: assert property (
      @(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_class <= CLASS_PLAIN)
   ) else $error("response carries an undefined class");

endmodule

// ===== sim/tb_two_mode_priority_job_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_mode_priority_job_queue
// Self-checking testbench for the two-mode priority job queue.
// ----------------------------------------------------------------------------
// Requests go in on the req_ stream and every request yields exactly one
// response on the rsp_ stream. A behavioral copy of the queue (slots, classes,
// sequence numbers, mode) runs beside the block. Each accepted request is
// applied to it and the outcome is queued. A monitor compares each response,
// field by field, with the oldest queued outcome. Directed tests cover mode
// reordering, class ties and a full queue. Random traffic then swings the
// occupancy between empty and full under three idling patterns, with the mode
// rewritten while the block is idle.
// ----------------------------------------------------------------------------
module tb_two_mode_priority_job_queue;
   import tmpq_pkg::*;

   localparam int DEPTH      = DEFAULT_QUEUE_DEPTH;
   // The slowest request is a dequeue, which scans every slot.
   localparam int LATENCY    = DEPTH + 3;
   // Cycles in a row without any handshake before the run is declared hung.
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [15:0]            tag;
      logic [KIND_BITS-1:0]   kind;
      logic [CLASS_BITS-1:0]  prio;
      logic [SEQ_BITS-1:0]    seq;
      logic [OCC_BITS-1:0]    occ;
   } job_outcome_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata;
   logic                      req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0]    rsp_tuser;
   logic                      csr_wen;
   logic                      csr_wdata;

   // Behavioral copy of the queue contents.
   logic                      slot_held [DEPTH];
   logic [CLASS_BITS-1:0]     slot_prio [DEPTH];
   logic [SEQ_BITS-1:0]       slot_seq  [DEPTH];
   logic [KIND_BITS-1:0]      slot_kind [DEPTH];
   logic [15:0]               slot_tag  [DEPTH];
   logic [SEQ_BITS-1:0]       next_seq;
   logic                      fifo_order;

   job_outcome_type           awaited_outcomes [$];
   job_outcome_type           head_outcome;
   int                        fault_count = 0;
   int                        stall_cycles = 0;
   int                        send_idle_pct;
   int                        recv_idle_pct;

   two_mode_priority_job_queue #(
      .QUEUE_DEPTH (DEPTH),
      .TAG_BITS    (DEFAULT_TAG_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Queue behavior
   // ------------------------------------------------------------------------

   // Updates outrank every query; among queries the most selective field wins.
   function automatic logic [CLASS_BITS-1:0] job_priority(input logic [1:0] kind,
                                                           input logic [6:0] flags);
      if (kind == KIND_INSERT || kind == KIND_DELETE) return CLASS_UPDATE;
      if (flags[FLAG_ZIP]) return CLASS_ZIP;
      if (flags[FLAG_LAT_MIN] | flags[FLAG_LAT_MAX] | flags[FLAG_LON_MIN] |
          flags[FLAG_LON_MAX]) return CLASS_BOUND;
      if (flags[FLAG_BOROUGH] | flags[FLAG_AGENCY]) return CLASS_AREA;
      return CLASS_PLAIN;
   endfunction

   // Sequence a is older than b when a - b, taken modulo 2^32, is negative.
   function automatic logic seq_is_older(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return diff[31];
   endfunction

   // True when slot a must be handed out before slot b under the current mode.
   function automatic logic leaves_first(input int a, input int b);
      if (!fifo_order && slot_prio[a] != slot_prio[b]) return slot_prio[a] < slot_prio[b];
      return seq_is_older(slot_seq[a], slot_seq[b]);
   endfunction

   function automatic job_outcome_type queue_model_step(input logic op,
                                                        input logic [1:0] kind,
                                                        input logic [15:0] tag,
                                                        input logic [6:0] flags);
      job_outcome_type res;
      int              slot;
      int              i;
      slot = -1;
      res  = '0;
      if (op == OP_ENQUEUE) begin
         // The job goes into the lowest free slot; a refused job keeps its
         // own fields in the response but gets no sequence number.
         for (i = DEPTH - 1; i >= 0; i--) begin
            if (!slot_held[i]) slot = i;
         end
         res.tag  = tag;
         res.kind = kind;
         res.prio = job_priority(kind, flags);
         if (slot < 0) begin
            res.status = ST_FULL;
         end else begin
            slot_held[slot] = 1'b1;
            slot_prio[slot] = res.prio;
            slot_seq[slot]  = next_seq;
            slot_kind[slot] = kind;
            slot_tag[slot]  = tag;
            res.status      = ST_ENQUEUED;
            res.seq         = next_seq;
            next_seq        = next_seq + 32'd1;
         end
      end else begin
         // Strict comparison keeps the lowest slot on a full tie.
         for (i = 0; i < DEPTH; i++) begin
            if (slot_held[i] && (slot < 0 || leaves_first(i, slot))) slot = i;
         end
         if (slot < 0) begin
            res.status = ST_EMPTY;
         end else begin
            slot_held[slot] = 1'b0;
            res.status      = ST_RETURNED;
            res.tag         = slot_tag[slot];
            res.kind        = slot_kind[slot];
            res.prio        = slot_prio[slot];
            res.seq         = slot_seq[slot];
         end
      end
      for (i = 0; i < DEPTH; i++) res.occ += OCC_BITS'(slot_held[i]);
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Presents one request, possibly after some idle cycles, and holds it until
   // it is accepted. The outcome is worked out at the accepting edge.
   task automatic send_request(input logic op, input logic [1:0] kind,
                               input logic [15:0] tag, input logic [6:0] flags);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, flags, tag, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      awaited_outcomes.push_back(queue_model_step(op, kind, tag, flags));
   endtask

   // Stops sending and waits until every response has come back.
   task automatic await_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
   endtask

   // Only called while the block is idle, so the copy can follow at once.
   task automatic write_mode(input logic mode);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= mode;
      @(negedge clock);
      csr_wen   <= 1'b0;
      fifo_order = mode;
   endtask

   task automatic random_burst(input int count);
      int         enq_pct;
      int         n;
      logic [6:0] flags;
      enq_pct = 50;
      for (n = 0; n < count; n++) begin
         // Change the mix every so often so the queue runs both full and dry.
         if (n % 20 == 0) enq_pct = 20 + 30 * $urandom_range(2);
         if ($urandom_range(99) < enq_pct) begin
            case ($urandom_range(3))
               0: flags = '0;
               1: flags = 7'($urandom_range(127));
               2: flags = 7'($urandom_range(127) & $urandom_range(127) &
                             $urandom_range(127));
               default: flags = 7'd1 << $urandom_range(6);
            endcase
            send_request(OP_ENQUEUE, 2'($urandom_range(3)), 16'($urandom_range(16'hFFFF)),
                         flags);
         end else begin
            // The payload of a dequeue is ignored by the block, so fill it
            // with noise.
            send_request(OP_DEQUEUE, 2'($urandom_range(3)), 16'($urandom_range(16'hFFFF)),
                         7'($urandom_range(127)));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Jobs stored in FIFO mode are handed out by class once the mode changes,
   // and by arrival again after it changes back. Flags on updates are ignored,
   // the two updates tie on class and go out oldest first, and the last
   // dequeue finds the queue empty.
   task automatic test_mode_reorder();
      send_request(OP_ENQUEUE, KIND_QUERY,   16'h0000, 7'd0);
      send_request(OP_ENQUEUE, KIND_FORWARD, 16'hFFFF, 7'd1 << FLAG_AGENCY);
      send_request(OP_ENQUEUE, KIND_QUERY,   16'h5AA5, 7'd1 << FLAG_LAT_MAX);
      send_request(OP_ENQUEUE, KIND_INSERT,  16'hA55A, 7'h7F);
      send_request(OP_ENQUEUE, KIND_FORWARD, 16'h1234, 7'h7F);
      send_request(OP_ENQUEUE, KIND_DELETE,  16'h8001, 7'd0);
      await_idle();
      write_mode(1'b0);
      repeat (3) send_request(OP_DEQUEUE, KIND_QUERY, 16'h0000, 7'd0);
      await_idle();
      write_mode(1'b1);
      repeat (4) send_request(OP_DEQUEUE, KIND_DELETE, 16'hFFFF, 7'h7F);
   endtask

   // Fills every slot and then offers one job too many, which is refused.
   task automatic test_full_queue();
      int i;
      for (i = 0; i <= DEPTH; i++) begin
         send_request(OP_ENQUEUE, 2'(i % 4), 16'(16'h0100 + i), 7'($urandom_range(127)));
      end
   endtask

   // Random traffic in both modes, the mode being rewritten only while idle.
   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      await_idle();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      write_mode(1'b0);
      random_burst(85);
      await_idle();
      write_mode(1'b1);
      random_burst(85);
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         if (fault_count < 10) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
         end
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_outcomes.size() == 0) begin
            if (fault_count < 10) begin
               $display("%0t: response with no request outstanding", $realtime);
            end
            fault_count++;
         end else begin
            head_outcome = awaited_outcomes.pop_front();
            compare_field("status",    32'(head_outcome.status), 32'(rsp_tuser));
            compare_field("tag",       32'(head_outcome.tag),    32'(rsp_tdata[15:0]));
            compare_field("kind",      32'(head_outcome.kind),   32'(rsp_tdata[17:16]));
            compare_field("class",     32'(head_outcome.prio),   32'(rsp_tdata[20:18]));
            compare_field("sequence",  head_outcome.seq,         rsp_tdata[52:21]);
            compare_field("occupancy", 32'(head_outcome.occ),    32'(rsp_tdata[57:53]));
         end
      end
   end

   // Watchdog: the run is hung when no request or response moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------

   initial begin
      int i;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = OP_ENQUEUE;
      csr_wen       = 1'b0;
      csr_wdata     = 1'b1;
      send_idle_pct = 32;
      recv_idle_pct = 53;
      next_seq      = '0;
      fifo_order    = 1'b1;
      for (i = 0; i < DEPTH; i++) begin
         slot_held[i] = 1'b0;
         slot_prio[i] = '0;
         slot_seq[i]  = '0;
         slot_kind[i] = '0;
         slot_tag[i]  = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_mode_reorder();
      test_full_queue();
      // Sender idles 32 in 100 and receiver 53, then swapped, then no idling.
      test_random_traffic(32, 53);
      test_random_traffic(53, 32);
      test_random_traffic(0, 0);

      await_idle();
      repeat (LATENCY + 5) @(posedge clock);
      if (fault_count == 0 && awaited_outcomes.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
